[rtl/omni_wheel_mixer_hbridge_pwm_top_defines.svh]
// Assertion macros shared by the omni wheel mixer RTL.
`ifndef OMNI_WHEEL_MIXER_HBRIDGE_PWM_TOP_DEFINES_SVH
`define OMNI_WHEEL_MIXER_HBRIDGE_PWM_TOP_DEFINES_SVH

// Immediate-style check that holds at every clock edge out of reset.
`define OWM_CHECK(LBL, COND, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (COND)) \
        else $error(MSG);

// Same-cycle implication.
`define OWM_IMPLY(LBL, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANTE) |-> (CONS)) \
        else $error(MSG);

`endif

[rtl/owm_pkg.sv]
// Package with constants and tables for the omni wheel mixer.
package owm_pkg;

    localparam int PWM_FULL_SCALE_DEF = 255;
    localparam int Q_FRAC    = 14;
    localparam int Q_ONE     = 16384;
    localparam int DIV_STEPS = Q_FRAC + 1;
    localparam int NUM_WHEEL = 4;

    localparam logic [15:0] SIN_A = 16'd25736;
    localparam logic [15:0] SIN_B = 16'd10512;
    localparam logic [15:0] SIN_C = 16'd1160;

    typedef enum logic [2:0] {
        CFG_YAW_NEGATE  = 3'd0,
        CFG_SPEED_LIMIT = 3'd1,
        CFG_M1_GAIN     = 3'd2,
        CFG_M2_GAIN     = 3'd3,
        CFG_M3_GAIN     = 3'd4,
        CFG_M4_GAIN     = 3'd5
    } t_cfg_idx;

    // Wheel angle offsets: -45, +45, +135, -135 degrees as binary angles.
    localparam logic [15:0] WHEEL_OFFS [NUM_WHEEL] = '{16'hE000, 16'h2000, 16'h6000, 16'hA000};

    // Motor to wheel mapping; motors 3 and 4 are crossed.
    localparam logic [1:0] MOTOR_WHEEL [NUM_WHEEL] = '{2'd0, 2'd1, 2'd3, 2'd2};

endpackage

[rtl/omni_wheel_mixer_hbridge_pwm_top.sv]
// X-drive omni wheel mixer with H-bridge PWM split, fully pipelined.
//
// The block takes one drive command per cycle while the output is not
// stalled and returns the eight pin duties through seven stages of angle,
// sine, mixing and peak search, fifteen stages of the restoring divider
// that normalizes the wheels by the largest magnitude when it exceeds one
// (one quotient bit per stage), and two stages of PWM scaling and motor
// gain. A stall on the output freezes the whole pipeline, so no item is
// lost or repeated. Configuration writes are always taken and should only
// be made while the pipeline holds no item.
`include "omni_wheel_mixer_hbridge_pwm_top_defines.svh"

module omni_wheel_mixer_hbridge_pwm_top #(
    parameter int PWM_FULL_SCALE = owm_pkg::PWM_FULL_SCALE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_heading,
    input  logic [15:0] i_robot_yaw,
    input  logic [15:0] i_magnitude,
    input  logic signed [15:0] i_spin,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_m1_forward,
    output logic [7:0]  o_m1_reverse,
    output logic [7:0]  o_m2_forward,
    output logic [7:0]  o_m2_reverse,
    output logic [7:0]  o_m3_forward,
    output logic [7:0]  o_m3_reverse,
    output logic [7:0]  o_m4_forward,
    output logic [7:0]  o_m4_reverse,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import owm_pkg::*;

    localparam int FSW  = $clog2(PWM_FULL_SCALE + 1);
    localparam int PW   = FSW + 2;
    localparam int LAST = DIV_STEPS - 1;

    // Configuration registers.
    logic              r_yaw_neg;
    logic [15:0]       r_speed_lim;
    logic signed [15:0] r_gain [NUM_WHEEL];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_neg   <= 1'b0;
            r_speed_lim <= 16'(Q_ONE);
            for (int i = 0; i < NUM_WHEEL; i++) r_gain[i] <= 16'(Q_ONE);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_YAW_NEGATE:  r_yaw_neg   <= i_cfg_data[0];
                CFG_SPEED_LIMIT: r_speed_lim <= i_cfg_data;
                CFG_M1_GAIN:     r_gain[0]   <= i_cfg_data;
                CFG_M2_GAIN:     r_gain[1]   <= i_cfg_data;
                CFG_M3_GAIN:     r_gain[2]   <= i_cfg_data;
                CFG_M4_GAIN:     r_gain[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves unless a finished item is held.
    logic en;
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // Valid bits, one per stage.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9;
    logic r_dvld [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0; r_v9 <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++) r_dvld[k] <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_dvld[0] <= r_v7;
            for (int k = 1; k < DIV_STEPS; k++) r_dvld[k] <= r_dvld[k-1];
            r_v8 <= r_dvld[LAST];
            r_v9 <= r_v8;
        end
    end
    assign o_out_valid = r_v9;

    // Stage 1: speed clamp and body-relative angle.
    logic [15:0]        r1_theta, r1_s;
    logic signed [15:0] r1_spin;
    logic [15:0]        n_eff_yaw;
    assign n_eff_yaw = r_yaw_neg ? 16'(16'd0 - i_robot_yaw) : i_robot_yaw;

    // Stage 2 .. 5: sine polynomial per wheel.
    logic [14:0] r2_z [NUM_WHEEL], r2_z2 [NUM_WHEEL];
    logic        r2_neg [NUM_WHEEL];
    logic [15:0] r2_s, r3_s, r4_s, r5_s;
    logic signed [15:0] r2_spin, r3_spin, r4_spin, r5_spin;
    logic [14:0] r3_z [NUM_WHEEL], r3_z2 [NUM_WHEEL], r4_z [NUM_WHEEL];
    logic [13:0] r3_t [NUM_WHEEL];
    logic [14:0] r4_t [NUM_WHEEL];
    logic        r3_neg [NUM_WHEEL], r4_neg [NUM_WHEEL], r5_neg [NUM_WHEEL];
    logic [14:0] r5_sin [NUM_WHEEL];

    // Stage 6: mixed wheel speed; stage 7: magnitude and peak.
    logic signed [17:0] r6_w [NUM_WHEEL];
    logic [16:0] r7_abs [NUM_WHEEL];
    logic        r7_sg [NUM_WHEEL];
    logic [16:0] r7_max;

    logic [15:0] n_ang [NUM_WHEEL];
    logic [14:0] n_z [NUM_WHEEL];
    logic [29:0] n_zz [NUM_WHEEL];
    logic [26:0] n_p3 [NUM_WHEEL];
    logic [28:0] n_p4 [NUM_WHEEL];
    logic [29:0] n_p5 [NUM_WHEEL];
    logic [14:0] n_t5 [NUM_WHEEL];
    logic [30:0] n_p6 [NUM_WHEEL];
    logic signed [17:0] n_w [NUM_WHEEL];
    logic [16:0] n_abs [NUM_WHEEL];
    logic [16:0] n_m01, n_m23, n_max;

    always_comb begin
        for (int i = 0; i < NUM_WHEEL; i++) begin
            n_ang[i] = r1_theta + WHEEL_OFFS[i];
            n_z[i]   = n_ang[i][14] ? 15'(15'd16384 - {1'b0, n_ang[i][13:0]})
                                    : {1'b0, n_ang[i][13:0]};
            n_zz[i]  = n_z[i] * n_z[i];
            n_p3[i]  = 27'(SIN_C) * 27'(r2_z2[i]);
            n_p4[i]  = 29'(r3_t[i]) * 29'(r3_z2[i]);
            n_p5[i]  = 30'(r4_t[i]) * 30'(r4_z[i]);
            n_t5[i]  = (n_p5[i][29:14] > 16'(Q_ONE)) ? 15'(Q_ONE) : n_p5[i][28:14];
            n_p6[i]  = 31'(r5_s) * 31'(r5_sin[i]);
            n_w[i]   = (r5_neg[i] ? -$signed({1'b0, n_p6[i][30:14]})
                                  : $signed({1'b0, n_p6[i][30:14]})) + 18'(r5_spin);
            n_abs[i] = r6_w[i][17] ? 17'(-r6_w[i]) : 17'(r6_w[i]);
        end
        n_m01 = (n_abs[0] > n_abs[1]) ? n_abs[0] : n_abs[1];
        n_m23 = (n_abs[2] > n_abs[3]) ? n_abs[2] : n_abs[3];
        n_max = (n_m01 > n_m23) ? n_m01 : n_m23;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_theta <= 16'(i_heading - n_eff_yaw);
            r1_s     <= (i_magnitude > r_speed_lim) ? r_speed_lim : i_magnitude;
            r1_spin  <= i_spin;
            r2_s <= r1_s; r3_s <= r2_s; r4_s <= r3_s; r5_s <= r4_s;
            r2_spin <= r1_spin; r3_spin <= r2_spin; r4_spin <= r3_spin;
            r5_spin <= r4_spin;
            for (int i = 0; i < NUM_WHEEL; i++) begin
                r2_z[i]   <= n_z[i];
                r2_z2[i]  <= n_zz[i][28:14];
                r2_neg[i] <= n_ang[i][15];
                r3_z[i]   <= r2_z[i];
                r3_z2[i]  <= r2_z2[i];
                r3_neg[i] <= r2_neg[i];
                r3_t[i]   <= 14'(SIN_B - 16'(n_p3[i][26:14]));
                r4_z[i]   <= r3_z[i];
                r4_neg[i] <= r3_neg[i];
                r4_t[i]   <= 15'(SIN_A - 16'(n_p4[i][28:14]));
                r5_neg[i] <= r4_neg[i];
                r5_sin[i] <= n_t5[i];
                r6_w[i]   <= n_w[i];
                r7_abs[i] <= n_abs[i];
                r7_sg[i]  <= r6_w[i][17];
            end
            r7_max <= n_max;
        end
    end

    // Normalize: q = |w| * 2^14 / max if max > 2^14, else |w|; one bit per stage.
    logic [16:0] r_rem [DIV_STEPS][NUM_WHEEL];
    logic [14:0] r_q   [DIV_STEPS][NUM_WHEEL];
    logic        r_dsg [DIV_STEPS][NUM_WHEEL];
    logic [16:0] r_dv  [DIV_STEPS];
    logic        r_nd  [DIV_STEPS];

    logic        n_ge0 [NUM_WHEEL];
    logic [17:0] n_sh  [DIV_STEPS][NUM_WHEEL];
    logic        n_ge  [DIV_STEPS][NUM_WHEEL];

    always_comb begin
        for (int i = 0; i < NUM_WHEEL; i++) begin
            n_ge0[i] = r7_abs[i] >= r7_max;
            n_sh[0][i] = '0;
            n_ge[0][i] = 1'b0;
            for (int k = 1; k < DIV_STEPS; k++) begin
                n_sh[k][i] = {r_rem[k-1][i], 1'b0};
                n_ge[k][i] = n_sh[k][i] >= {1'b0, r_dv[k-1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= r7_max;
            r_nd[0] <= r7_max > 17'(Q_ONE);
            for (int i = 0; i < NUM_WHEEL; i++) begin
                r_dsg[0][i] <= r7_sg[i];
                r_rem[0][i] <= n_ge0[i] ? 17'(r7_abs[i] - r7_max) : r7_abs[i];
                r_q[0][i]   <= (r7_max > 17'(Q_ONE)) ? {n_ge0[i], 14'd0} : r7_abs[i][14:0];
            end
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_dv[k] <= r_dv[k-1];
                r_nd[k] <= r_nd[k-1];
                for (int i = 0; i < NUM_WHEEL; i++) begin
                    r_dsg[k][i] <= r_dsg[k-1][i];
                    r_rem[k][i] <= n_ge[k][i] ? 17'(n_sh[k][i] - {1'b0, r_dv[k-1]})
                                              : n_sh[k][i][16:0];
                    r_q[k][i]   <= r_q[k-1][i]
                                   | (15'(r_nd[k-1] && n_ge[k][i]) << (LAST - k));
                end
            end
        end
    end

    // PWM scaling and motor gain.
    logic [FSW-1:0] r8_m [NUM_WHEEL];
    logic           r8_sg [NUM_WHEEL];
    logic [FSW+14:0] n_pm [NUM_WHEEL];
    logic [15:0]     n_gabs [NUM_WHEEL];
    logic [FSW+15:0] n_pg [NUM_WHEEL];
    logic [PW-1:0]   n_pd [NUM_WHEEL];
    logic [PW-1:0]   n_duty [NUM_WHEEL];
    logic            n_dneg [NUM_WHEEL];
    logic [7:0]      r_fwd [NUM_WHEEL], r_rev [NUM_WHEEL];

    always_comb begin
        for (int i = 0; i < NUM_WHEEL; i++) begin
            n_pm[i]   = (FSW+15)'(r_q[LAST][i]) * (FSW+15)'(PWM_FULL_SCALE);
            n_gabs[i] = r_gain[i][15] ? 16'(-r_gain[i]) : r_gain[i];
            n_pg[i]   = (FSW+16)'(r8_m[MOTOR_WHEEL[i]]) * (FSW+16)'(n_gabs[i]);
            n_pd[i]   = n_pg[i][FSW+15:14];
            n_duty[i] = (n_pd[i] > PW'(PWM_FULL_SCALE)) ? PW'(PWM_FULL_SCALE) : n_pd[i];
            n_dneg[i] = r8_sg[MOTOR_WHEEL[i]] ^ r_gain[i][15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NUM_WHEEL; i++) begin
                r8_m[i]  <= n_pm[i][FSW+13:14];
                r8_sg[i] <= r_dsg[LAST][i];
                r_fwd[i] <= n_dneg[i] ? 8'd0 : 8'(n_duty[i]);
                r_rev[i] <= n_dneg[i] ? 8'(n_duty[i]) : 8'd0;
            end
        end
    end

    assign o_m1_forward = r_fwd[0];
    assign o_m1_reverse = r_rev[0];
    assign o_m2_forward = r_fwd[1];
    assign o_m2_reverse = r_rev[1];
    assign o_m3_forward = r_fwd[2];
    assign o_m3_reverse = r_rev[2];
    assign o_m4_forward = r_fwd[3];
    assign o_m4_reverse = r_rev[3];

    // A full-scale duty of up to 255 can never drive both pins of a bridge.
    `OWM_IMPLY(a_m1_pins, o_out_valid && PWM_FULL_SCALE <= 255,
        o_m1_forward == 8'd0 || o_m1_reverse == 8'd0, "motor 1 drives both pins")
    `OWM_IMPLY(a_m4_pins, o_out_valid && PWM_FULL_SCALE <= 255,
        o_m4_forward == 8'd0 || o_m4_reverse == 8'd0, "motor 4 drives both pins")
    `OWM_IMPLY(a_peak, r_v7,
        r7_max >= r7_abs[0] && r7_max >= r7_abs[1] && r7_max >= r7_abs[2] && r7_max >= r7_abs[3],
        "peak below a wheel magnitude")
    `OWM_CHECK(a_quot,
        !r_dvld[LAST] || (r_q[LAST][0] <= 15'(Q_ONE) && r_q[LAST][3] <= 15'(Q_ONE)),
        "normalized wheel above one")

endmodule

[verif/tb.sv]
// Self-checking testbench for the X-drive omni wheel mixer with H-bridge PWM split.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import owm_pkg::*;

    localparam int FULL_SCALE = 255;
    localparam int LATENCY = 24;
    localparam int N_RANDOM = 760;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] heading;
        logic [15:0] robot_yaw;
        logic [15:0] magnitude;
        logic [15:0] spin;
    } t_command;

    typedef struct packed {
        logic [7:0] m1_fwd, m1_rev, m2_fwd, m2_rev, m3_fwd, m3_rev, m4_fwd, m4_rev;
    } t_duties;

    typedef struct {
        t_command cmd;
        bit       has_duties;
        t_duties  duties;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_heading = '0, i_robot_yaw = '0, i_magnitude = '0;
    logic signed [15:0] i_spin = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_m1_forward, o_m1_reverse, o_m2_forward, o_m2_reverse;
    logic [7:0]  o_m3_forward, o_m3_reverse, o_m4_forward, o_m4_reverse;
    t_duties     got;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    omni_wheel_mixer_hbridge_pwm_top dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .i_heading, .i_robot_yaw, .i_magnitude, .i_spin,
        .o_out_valid, .i_out_stall,
        .o_m1_forward, .o_m1_reverse,
        .o_m2_forward, .o_m2_reverse,
        .o_m3_forward, .o_m3_reverse,
        .o_m4_forward, .o_m4_reverse,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    assign got = {o_m1_forward, o_m1_reverse, o_m2_forward, o_m2_reverse,
                  o_m3_forward, o_m3_reverse, o_m4_forward, o_m4_reverse};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the register file
    bit           cur_yaw_negate;
    logic [15:0]  cur_speed_limit;
    logic signed [15:0] cur_gain [4];

    t_duties pending_duties [$];
    int      mismatches = 0;
    longint  cycle = 0;
    bit      calm = 1'b0;       // no idling in the final stretch
    bit      long_hold = 1'b0;

    function automatic longint binary_sine(logic [15:0] ang);
        longint unsigned r, z, z2, t;
        logic [1:0] quad;
        quad = ang[15:14];
        r = ang[13:0];
        z = quad[0] ? 16384 - r : r;
        z2 = (z * z) >> 14;
        t = (1160 * z2) >> 14;
        t = ((10512 - t) * z2) >> 14;
        t = ((25736 - t) * z) >> 14;
        if (t > 16384) t = 16384;
        return quad[1] ? -longint'(t) : longint'(t);
    endfunction

    function automatic t_duties mix_wheels(t_command c);
        logic [15:0] offs [4] = '{16'hE000, 16'h2000, 16'h6000, 16'hA000};
        int wheel_of_motor [4] = '{0, 1, 3, 2};
        longint s, sn, mag, peak, p;
        longint w [4];
        logic [15:0] eff_yaw, theta;
        logic [7:0] fwd, rev;
        t_duties d;
        s = c.magnitude > cur_speed_limit ? cur_speed_limit : c.magnitude;
        eff_yaw = cur_yaw_negate ? 16'(-c.robot_yaw) : c.robot_yaw;
        theta = c.heading - eff_yaw;
        peak = 0;
        for (int i = 0; i < 4; i++) begin
            sn = binary_sine(16'(theta + offs[i]));
            mag = (s * (sn < 0 ? -sn : sn)) >>> 14;
            w[i] = (sn < 0 ? -mag : mag) + longint'($signed(c.spin));
            mag = w[i] < 0 ? -w[i] : w[i];
            if (mag > peak) peak = mag;
        end
        if (peak > 16384)
            for (int i = 0; i < 4; i++) w[i] = (w[i] * 16384) / peak;
        for (int m = 0; m < 4; m++) begin
            p = (w[wheel_of_motor[m]] * FULL_SCALE) / 16384;
            p = (p * longint'(cur_gain[m])) / 16384;
            if (p > FULL_SCALE) p = FULL_SCALE;
            if (p < -FULL_SCALE) p = -FULL_SCALE;
            fwd = p > 0 ? 8'(p) : 8'd0;
            rev = p < 0 ? 8'(-p) : 8'd0;
            d[63 - 16*m -: 8] = fwd;
            d[55 - 16*m -: 8] = rev;
        end
        return d;
    endfunction

    // Output side: stall bursts, one long hold, and checking.
    initial begin : receiver
        int gap;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                long_hold = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 19);
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_duties exp_d;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_duties.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: %h", got);
            end else begin
                exp_d = pending_duties.pop_front();
                if (got !== exp_d) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("duty mismatch: expected %h got %h", exp_d, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle++;
        if (cycle > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_YAW_NEGATE:  cur_yaw_negate = data[0];
            CFG_SPEED_LIMIT: cur_speed_limit = data;
            CFG_M1_GAIN:     cur_gain[0] = data;
            CFG_M2_GAIN:     cur_gain[1] = data;
            CFG_M3_GAIN:     cur_gain[2] = data;
            default:         cur_gain[3] = data;
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_duties.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Offers one command; a typed-in expectation overrides the prediction.
    task automatic send_command(t_command c, bit has_d, t_duties d, bit may_idle);
        int gap;
        if (may_idle && !calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_heading, i_robot_yaw, i_magnitude, i_spin} <= c;
        do @(posedge i_clk); while (o_in_stall);
        pending_duties.push_back(has_d ? d : mix_wheels(c));
    endtask

    function automatic t_command random_command();
        t_command c;
        c = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: c.magnitude = 16'($urandom_range(0, 20000));
            1: c.spin = 16'($signed($urandom_range(0, 8000)) - 4000);
            default: ;
        endcase
        return c;
    endfunction

    task automatic random_gains();
        write_reg(CFG_YAW_NEGATE, 16'($urandom_range(0, 1)));
        write_reg(CFG_SPEED_LIMIT, 16'($urandom));
        write_reg(CFG_M1_GAIN, 16'($urandom));
        write_reg(CFG_M2_GAIN, 16'($urandom));
        write_reg(CFG_M3_GAIN, 16'($urandom));
        write_reg(CFG_M4_GAIN, 16'($urandom));
    endtask

    initial begin : stimulus
        t_row rows [$];
        t_duties all_zero;
        t_command c;
        all_zero = '0;
        cur_yaw_negate = 1'b0;
        cur_speed_limit = 16'd16384;
        foreach (cur_gain[i]) cur_gain[i] = 16'sd16384;

        // Zero speed and spin gives zero duty on every pin.
        rows.push_back('{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1, all_zero});
        rows.push_back('{'{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000}, 1, all_zero});
        // Full positive spin alone drives all forward pins to full scale.
        rows.push_back('{'{16'h1234, 16'h0000, 16'h0000, 16'sd16384}, 1,
                         {8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0}});
        rows.push_back('{'{16'h0000, 16'h0000, 16'h0000, -16'sd16384}, 1,
                         {8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255}});
        rows.push_back('{'{16'h0000, 16'h0000, 16'hFFFF, 16'h0000}, 0, all_zero});
        rows.push_back('{'{16'h4000, 16'h0000, 16'h4000, 16'h0000}, 0, all_zero});
        rows.push_back('{'{16'h8000, 16'h4000, 16'h4000, 16'h7FFF}, 0, all_zero});
        rows.push_back('{'{16'hC000, 16'hFFFF, 16'h2000, 16'h8000}, 0, all_zero});
        rows.push_back('{'{16'h2000, 16'h0000, 16'h4000, 16'h0000}, 0, all_zero});
        rows.push_back('{'{16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF}, 0, all_zero});
        rows.push_back('{'{16'h5555, 16'hAAAA, 16'h3000, 16'h1000}, 0, all_zero});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_command(rows[i].cmd, rows[i].has_duties, rows[i].duties, 1);
        drain();

        // Extreme settings: negated yaw, zero and full limit, extreme gains.
        write_reg(CFG_YAW_NEGATE, 16'd1);
        write_reg(CFG_SPEED_LIMIT, 16'd0);
        write_reg(CFG_M1_GAIN, 16'h7FFF);
        write_reg(CFG_M2_GAIN, 16'h8000);
        write_reg(CFG_M3_GAIN, 16'h0000);
        write_reg(CFG_M4_GAIN, 16'hC000);
        foreach (rows[i]) send_command(rows[i].cmd, 0, all_zero, 1);
        drain();
        write_reg(CFG_SPEED_LIMIT, 16'hFFFF);
        foreach (rows[i]) send_command(rows[i].cmd, 0, all_zero, 1);
        drain();

        // Back pressure: the receiver holds while commands keep coming.
        long_hold = 1'b1;
        for (int n = 0; n < 60; n++) send_command(random_command(), 0, all_zero, 0);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 0) begin
                write_reg(CFG_YAW_NEGATE, 16'd0);
                write_reg(CFG_SPEED_LIMIT, 16'd16384);
                for (int g = 0; g < 4; g++) write_reg(t_cfg_idx'(CFG_M1_GAIN + g), 16'd16384);
            end else begin
                random_gains();
            end
            if (phase == 4) calm = 1'b1;
            for (int n = 0; n < N_RANDOM / 5; n++)
                send_command(random_command(), 0, all_zero, 1);
            drain();
        end

        if (mismatches == 0 && pending_duties.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
